// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk and off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and the type-id classifier of the structured field deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int FIELD_OFFSET_W      = 32;
  localparam int NUM_KNOWN           = 10;

  localparam logic [7:0]  PREFIX_BYTE = 8'h5A;
  localparam logic [15:0] HEADER_LEN  = 16'd8;

  localparam logic [23:0] KNOWN_IDS [NUM_KNOWN] = '{
    24'hD3A9A8, 24'hD3A090, 24'hD3ABCC, 24'hD3A8AF, 24'hD3A9AF,
    24'hD3A8CE, 24'hD3A8CC, 24'hD3A788, 24'hD3A8C6, 24'hD3EEEE
  };

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_PREFIX = 2'd1,
    ERR_SHORT  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LEN_HI = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_ID_0   = 4'd3,
    PH_ID_1   = 4'd4,
    PH_ID_2   = 4'd5,
    PH_FLAG   = 4'd6,
    PH_RSV_0  = 4'd7,
    PH_RSV_1  = 4'd8,
    PH_SKIP   = 4'd9
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] field_offset;
    logic [15:0] field_length;
    logic [3:0]  type_class;
    logic [23:0] type_id;
    logic [7:0]  flag_byte;
    logic [15:0] reserved_bytes;
    err_t        error_code;
  } result_t;

  // 0 when unknown, else 1-based position in the known list
  function automatic logic [3:0] classify(input logic [23:0] id);
    logic [3:0] cls;
    cls = '0;
    for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
      if (KNOWN_IDS[k] == id) begin
        cls = 4'(k + 1);
      end
    end
    return cls;
  endfunction

endpackage

// ----- rtl/core/sfd_if.sv -----
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels: the raw byte stream and the per-field result stream.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface sfd_field_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_offset;
  logic [15:0] field_length;
  logic [3:0]  type_class;
  logic [23:0] type_id;
  logic [7:0]  flag_byte;
  logic [15:0] reserved_bytes;
  logic [1:0]  error_code;

  modport source (
    output valid, output field_offset, output field_length, output type_class,
    output type_id, output flag_byte, output reserved_bytes, output error_code,
    input ready
  );
  modport sink (
    input valid, input field_offset, input field_length, input type_class,
    input type_id, input flag_byte, input reserved_bytes, input error_code,
    output ready
  );
endinterface

// ----- rtl/core/sfd_parser.sv -----
// ----------------------------------------------------------------------------
// sfd_parser
// Introducer state machine: tracks the phase within a field, collects the
// introducer bytes and forms the result for the byte currently presented.
// ----------------------------------------------------------------------------
module sfd_parser #(
  parameter int OFFSET_BITS = sfd_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  output sfd_pkg::result_t  result
);

  localparam int OUT_W = sfd_pkg::FIELD_OFFSET_W;

  sfd_pkg::phase_t        phase, phase_next;
  logic [15:0]            skip_count, skip_count_next, skip_dec;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [15:0]            length_value, length_value_next;
  logic [23:0]            id_value, id_value_next;
  logic [7:0]             flag_value, flag_value_next;
  logic [7:0]             first_reserved, first_reserved_next;
  logic                   halted, halted_next;

  assign skip_dec = (skip_count == 16'd0) ? 16'd0 : skip_count - 16'd1;

  always_comb begin
    phase_next          = phase;
    skip_count_next     = skip_count;
    byte_offset_next    = byte_offset;
    start_offset_next   = start_offset;
    length_value_next   = length_value;
    id_value_next       = id_value;
    flag_value_next     = flag_value;
    first_reserved_next = first_reserved;
    halted_next         = halted;
    if (!halted) begin
      byte_offset_next = byte_offset + OFFSET_BITS'(1);
      case (phase)
        sfd_pkg::PH_LEN_HI: begin
          length_value_next = {data_byte, 8'h00};
          phase_next        = sfd_pkg::PH_LEN_LO;
        end
        sfd_pkg::PH_LEN_LO: begin
          length_value_next = {length_value[15:8], data_byte};
          phase_next        = sfd_pkg::PH_ID_0;
        end
        sfd_pkg::PH_ID_0: begin
          id_value_next = {data_byte, 16'h0000};
          phase_next    = sfd_pkg::PH_ID_1;
        end
        sfd_pkg::PH_ID_1: begin
          id_value_next = {id_value[23:16], data_byte, 8'h00};
          phase_next    = sfd_pkg::PH_ID_2;
        end
        sfd_pkg::PH_ID_2: begin
          id_value_next = {id_value[23:8], data_byte};
          phase_next    = sfd_pkg::PH_FLAG;
        end
        sfd_pkg::PH_FLAG: begin
          flag_value_next = data_byte;
          phase_next      = sfd_pkg::PH_RSV_0;
        end
        sfd_pkg::PH_RSV_0: begin
          first_reserved_next = data_byte;
          phase_next          = sfd_pkg::PH_RSV_1;
        end
        sfd_pkg::PH_RSV_1: begin
          if (length_value < sfd_pkg::HEADER_LEN) begin
            phase_next = sfd_pkg::PH_IDLE;
          end else begin
            skip_count_next = length_value - sfd_pkg::HEADER_LEN;
            phase_next = (length_value == sfd_pkg::HEADER_LEN) ?
                         sfd_pkg::PH_IDLE : sfd_pkg::PH_SKIP;
          end
        end
        sfd_pkg::PH_SKIP: begin
          skip_count_next = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_next = sfd_pkg::PH_IDLE;
          end
        end
        default: begin
          // expecting a prefix; anything else halts the block for good
          if (data_byte == sfd_pkg::PREFIX_BYTE) begin
            start_offset_next = byte_offset;
            phase_next        = sfd_pkg::PH_LEN_HI;
          end else begin
            halted_next = 1'b1;
            phase_next  = sfd_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    result = '0;
    if (!halted) begin
      case (phase)
        sfd_pkg::PH_RSV_1: begin
          result.valid          = 1'b1;
          result.field_offset   = OUT_W'(start_offset);
          result.field_length   = length_value;
          result.type_class     = sfd_pkg::classify(id_value);
          result.type_id        = id_value;
          result.flag_byte      = flag_value;
          result.reserved_bytes = {first_reserved, data_byte};
          result.error_code     = (length_value < sfd_pkg::HEADER_LEN) ?
                                  sfd_pkg::ERR_SHORT : sfd_pkg::ERR_OK;
        end
        sfd_pkg::PH_LEN_HI, sfd_pkg::PH_LEN_LO, sfd_pkg::PH_ID_0,
        sfd_pkg::PH_ID_1, sfd_pkg::PH_ID_2, sfd_pkg::PH_FLAG,
        sfd_pkg::PH_RSV_0, sfd_pkg::PH_SKIP: begin
          result = '0;
        end
        default: begin
          if (data_byte != sfd_pkg::PREFIX_BYTE) begin
            result.valid        = 1'b1;
            result.field_offset = OUT_W'(byte_offset);
            result.error_code   = sfd_pkg::ERR_PREFIX;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfd_pkg::PH_IDLE;
      skip_count     <= '0;
      byte_offset    <= '0;
      start_offset   <= '0;
      length_value   <= '0;
      id_value       <= '0;
      flag_value     <= '0;
      first_reserved <= '0;
      halted         <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      skip_count     <= skip_count_next;
      byte_offset    <= byte_offset_next;
      start_offset   <= start_offset_next;
      length_value   <= length_value_next;
      id_value       <= id_value_next;
      flag_value     <= flag_value_next;
      first_reserved <= first_reserved_next;
      halted         <= halted_next;
    end
  end

endmodule

// ----- rtl/core/structured_field_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// structured_field_deframer_unit
// Splits a byte stream into structured fields and reports each introducer.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the byte stream is not stalled and gives one
// result per field introducer. A byte is latched in an input register, run
// through the introducer state machine once the output register is free, and
// its result (if any) lands in that output register, which drives the result
// port until the sink takes it. The block stalls the byte stream only while
// the output register holds a result that the sink has not taken. A bad
// prefix gives one error result, after which bytes are still taken but
// ignored until reset. The stream offset counter is OFFSET_BITS wide and
// wraps; its low 32 bits are reported.
module structured_field_deframer_unit #(
  parameter int OFFSET_BITS = sfd_pkg::OFFSET_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  sfd_byte_if.sink   stream,
  sfd_field_if.source fields
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             out_free;
  logic             s1_go;
  logic             out_valid;
  sfd_pkg::result_t res;
  sfd_pkg::result_t out_res;

  assign out_free     = !out_valid || fields.ready;
  assign s1_go        = s1_valid && out_free;
  assign stream.ready = !s1_valid || out_free;

  sfd_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .data_byte (s1_byte),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stream.ready) begin
        s1_valid <= stream.valid;
      end
      if (out_free) begin
        out_valid <= s1_go && res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready) begin
      s1_byte <= stream.data_byte;
    end
    if (out_free) begin
      out_res <= res;
    end
  end

  assign fields.valid          = out_valid;
  assign fields.field_offset   = out_res.field_offset;
  assign fields.field_length   = out_res.field_length;
  assign fields.type_class     = out_res.type_class;
  assign fields.type_id        = out_res.type_id;
  assign fields.flag_byte      = out_res.flag_byte;
  assign fields.reserved_bytes = out_res.reserved_bytes;
  assign fields.error_code     = out_res.error_code;

endmodule

// ----- rtl/core/sfd_checker.sv -----
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the result stream of the deframer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] field_offset,
  input logic [15:0] field_length,
  input logic [3:0]  type_class,
  input logic [23:0] type_id,
  input logic [7:0]  flag_byte,
  input logic [15:0] reserved_bytes,
  input logic [1:0]  error_code
);

  logic is_ok, is_prefix, is_short;
  logic prefix_clean, len_agrees, class_ok;

  assign is_ok     = error_code == sfd_pkg::ERR_OK;
  assign is_prefix = error_code == sfd_pkg::ERR_PREFIX;
  assign is_short  = error_code == sfd_pkg::ERR_SHORT;

  assign prefix_clean = field_length == 16'd0 && type_class == 4'd0 && type_id == 24'd0
                        && flag_byte == 8'd0 && reserved_bytes == 16'd0;
  assign len_agrees   = (is_ok && field_length >= sfd_pkg::HEADER_LEN)
                        || (is_short && field_length < sfd_pkg::HEADER_LEN);
  assign class_ok     = type_class <= 4'(sfd_pkg::NUM_KNOWN) && type_id[23:16] == 8'hD3;

  // a bad prefix result carries nothing but its offset
  `SFD_ASSERT_NOW(a_prefix_zero, out_valid && is_prefix, prefix_clean)
  // length check and error code agree
  `SFD_ASSERT_NOW(a_len_code, out_valid && !is_prefix, len_agrees)
  // a known class always belongs to the fixed id family
  `SFD_ASSERT_NOW(a_class_id, out_valid && type_class != 4'd0, class_ok)
  // a stalled result holds
  `SFD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(field_offset) && $stable(error_code))

endmodule

bind structured_field_deframer_unit sfd_checker u_sfd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (fields.valid),
  .out_ready      (fields.ready),
  .field_offset   (fields.field_offset),
  .field_length   (fields.field_length),
  .type_class     (fields.type_class),
  .type_id        (fields.type_id),
  .flag_byte      (fields.flag_byte),
  .reserved_bytes (fields.reserved_bytes),
  .error_code     (fields.error_code)
);

// ----- tb/tb_structured_field_deframer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_structured_field_deframer_unit
// Feeds byte streams of structured fields into the deframer and checks every
// field report against a cycle-free model of the introducer parser.
// ----------------------------------------------------------------------------
module tb_structured_field_deframer_unit;

  typedef struct packed {
    logic [31:0]    field_offset;
    logic [15:0]    field_length;
    logic [3:0]     type_class;
    logic [23:0]    type_id;
    logic [7:0]     flag_byte;
    logic [15:0]    reserved_bytes;
    sfd_pkg::err_t  error_code;
  } field_rec_t;

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;
  int   errors = 0;

  always #1 clk = ~clk;

  sfd_byte_if  byte_ch ();
  sfd_field_if field_ch ();

  structured_field_deframer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .fields (field_ch)
  );

  logic [7:0] byte_q [$];
  field_rec_t field_exp_q [$];

  // parser state mirrored from the block
  sfd_pkg::phase_t ph = sfd_pkg::PH_IDLE;
  logic [15:0] skip_cnt = '0;
  logic [31:0] offset_ctr = '0;
  logic [31:0] start_off = '0;
  logic [15:0] len_val = '0;
  logic [23:0] id_val = '0;
  logic [7:0]  flag_val = '0;
  logic [7:0]  rsv_hi = '0;
  logic        halted = 1'b0;

  task automatic deframe_byte(input logic [7:0] b);
    field_rec_t  r;
    logic [31:0] here;
    if (!halted) begin
      here = offset_ctr;
      offset_ctr = offset_ctr + 32'd1;
      case (ph)
        sfd_pkg::PH_LEN_HI: begin len_val = {b, 8'h00}; ph = sfd_pkg::PH_LEN_LO; end
        sfd_pkg::PH_LEN_LO: begin len_val[7:0] = b; ph = sfd_pkg::PH_ID_0; end
        sfd_pkg::PH_ID_0:   begin id_val = {b, 16'h0000}; ph = sfd_pkg::PH_ID_1; end
        sfd_pkg::PH_ID_1:   begin id_val[15:8] = b; ph = sfd_pkg::PH_ID_2; end
        sfd_pkg::PH_ID_2:   begin id_val[7:0] = b; ph = sfd_pkg::PH_FLAG; end
        sfd_pkg::PH_FLAG:   begin flag_val = b; ph = sfd_pkg::PH_RSV_0; end
        sfd_pkg::PH_RSV_0:  begin rsv_hi = b; ph = sfd_pkg::PH_RSV_1; end
        sfd_pkg::PH_RSV_1: begin
          r.field_offset   = start_off;
          r.field_length   = len_val;
          r.type_class     = 4'd0;
          for (int k = 0; k < sfd_pkg::NUM_KNOWN; k++) begin
            if (sfd_pkg::KNOWN_IDS[k] == id_val) begin
              r.type_class = 4'(k + 1);
              break;
            end
          end
          r.type_id        = id_val;
          r.flag_byte      = flag_val;
          r.reserved_bytes = {rsv_hi, b};
          if (len_val < sfd_pkg::HEADER_LEN) begin
            r.error_code = sfd_pkg::ERR_SHORT;
            ph = sfd_pkg::PH_IDLE;
          end else begin
            r.error_code = sfd_pkg::ERR_OK;
            skip_cnt = len_val - sfd_pkg::HEADER_LEN;
            ph = (skip_cnt == 16'd0) ? sfd_pkg::PH_IDLE : sfd_pkg::PH_SKIP;
          end
          field_exp_q.push_back(r);
        end
        sfd_pkg::PH_SKIP: begin
          if (skip_cnt > 16'd0) skip_cnt = skip_cnt - 16'd1;
          if (skip_cnt == 16'd0) ph = sfd_pkg::PH_IDLE;
        end
        default: begin
          if (b == sfd_pkg::PREFIX_BYTE) begin
            start_off = here;
            ph = sfd_pkg::PH_LEN_HI;
          end else begin
            r = '0;
            r.field_offset = here;
            r.error_code   = sfd_pkg::ERR_PREFIX;
            halted = 1'b1;
            ph = sfd_pkg::PH_IDLE;
            field_exp_q.push_back(r);
          end
        end
      endcase
    end
  endtask

  // byte source
  int idle_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= 8'h00;
      idle_left = 0;
    end else if (!(byte_ch.valid && !byte_ch.ready)) begin
      if (byte_ch.valid) begin
        deframe_byte(byte_ch.data_byte);
        void'(byte_q.pop_front());
      end
      if (idle_left > 0) begin
        idle_left--;
        byte_ch.valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        byte_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 13);
        byte_ch.valid <= 1'b0;
      end else begin
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= byte_q[0];
      end
    end
  end

  // field report sink
  int         hold_left = 0;
  int         results_seen = 0;
  logic       long_hold_done = 1'b0;
  field_rec_t exp_rec;
  field_rec_t act_rec;

  always @(posedge clk) begin
    if (rst) begin
      field_ch.ready <= 1'b0;
    end else begin
      if (field_ch.valid && field_ch.ready) begin
        if (field_exp_q.size() == 0) begin
          $display("%0t: unexpected field report: expected none, actual offset %h code %0d",
                   $time, field_ch.field_offset, field_ch.error_code);
          errors++;
        end else begin
          exp_rec = field_exp_q.pop_front();
          act_rec.field_offset   = field_ch.field_offset;
          act_rec.field_length   = field_ch.field_length;
          act_rec.type_class     = field_ch.type_class;
          act_rec.type_id        = field_ch.type_id;
          act_rec.flag_byte      = field_ch.flag_byte;
          act_rec.reserved_bytes = field_ch.reserved_bytes;
          act_rec.error_code     = sfd_pkg::err_t'(field_ch.error_code);
          if (exp_rec !== act_rec) begin
            $display("%0t: field report mismatch: expected %h, actual %h",
                     $time, exp_rec, act_rec);
            errors++;
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        field_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen == 20) begin
        // long back-pressure so the block fills up and stalls the stream
        long_hold_done = 1'b1;
        hold_left = 300;
        field_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 13);
        field_ch.ready <= 1'b0;
      end else begin
        field_ch.ready <= 1'b1;
      end
    end
  end

  // one whole field: prefix, introducer, then a body of length - 8 bytes (none if length < 8)
  task automatic add_field(input logic [15:0] len, input logic [23:0] id,
                           input logic [7:0] flag, input logic [15:0] rsv);
    int body_n;
    body_n = (len >= sfd_pkg::HEADER_LEN) ? int'(len - sfd_pkg::HEADER_LEN) : 0;
    byte_q.push_back(sfd_pkg::PREFIX_BYTE);
    byte_q.push_back(len[15:8]);
    byte_q.push_back(len[7:0]);
    byte_q.push_back(id[23:16]);
    byte_q.push_back(id[15:8]);
    byte_q.push_back(id[7:0]);
    byte_q.push_back(flag);
    byte_q.push_back(rsv[15:8]);
    byte_q.push_back(rsv[7:0]);
    for (int i = 0; i < body_n; i++) begin
      // prefix-like bytes inside a body must be skipped
      byte_q.push_back(($urandom_range(0, 7) == 0) ? sfd_pkg::PREFIX_BYTE : 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || field_exp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int          n_fields;
    int          sel;
    logic [15:0] len;
    logic [23:0] id;
    logic [7:0]  bad;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty body, short lengths, one-byte body, every known id
    add_field(16'd8, 24'hD3A9A8, 8'h00, 16'h0000);
    add_field(16'd0, 24'hFFFFFF, 8'hFF, 16'hFFFF);
    add_field(16'd7, 24'h000000, 8'hA5, 16'h5A5A);
    add_field(16'd9, 24'hD3A9A9, 8'h5A, 16'h0001);
    for (int k = 0; k < sfd_pkg::NUM_KNOWN; k++) begin
      add_field(16'(8 + k), sfd_pkg::KNOWN_IDS[k], 8'($urandom), 16'($urandom));
    end

    // sender waits for every report of the directed part
    wait_drained();

    n_fields = 0;
    while (n_fields < 10 || byte_q.size() < 180) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) len = 16'($urandom_range(0, 7));
      else if (sel == 2) len = 16'($urandom_range(8, 300));
      else len = 16'($urandom_range(8, 32));
      sel = $urandom_range(0, 3);
      if (sel < 2) id = sfd_pkg::KNOWN_IDS[$urandom_range(0, sfd_pkg::NUM_KNOWN - 1)];
      else if (sel == 2) id = 24'($urandom);
      else id = sfd_pkg::KNOWN_IDS[$urandom_range(0, sfd_pkg::NUM_KNOWN - 1)]
                ^ (24'd1 << $urandom_range(0, 23));
      add_field(len, id, 8'($urandom), 16'($urandom));
      n_fields++;
    end

    // bad prefix halts the parser; everything after it is ignored
    bad = 8'($urandom_range(0, 254));
    if (bad >= sfd_pkg::PREFIX_BYTE) bad = bad + 8'd1;
    byte_q.push_back(bad);
    add_field(16'd8, sfd_pkg::KNOWN_IDS[0], 8'($urandom), 16'($urandom));
    for (int i = 0; i < 8; i++) byte_q.push_back(8'($urandom));

    while (byte_q.size() > 100) @(negedge clk);
    calm = 1'b1;
    wait_drained();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sfd_pkg.sv
rtl/core/sfd_if.sv
rtl/core/sfd_parser.sv
rtl/core/structured_field_deframer_unit.sv
rtl/core/sfd_checker.sv
tb/tb_structured_field_deframer_unit.sv
